[rtl/pcrg_pkg.sv]
`timescale 1ns / 1ps
// pcrg_pkg: shared constants for the pinhole camera ray generator
// no dependencies

package pcrg_pkg;

  localparam int VFB      = 14;      // vector fraction bits
  localparam int PFB      = 16;      // plane fraction bits
  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = 13;
  localparam int CNT_W    = 12;
  localparam int PLANE_W  = 24;
  localparam int DIV_W    = 48;
  localparam int DIV_QW   = 29;
  localparam int ITER_W   = 5;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SQ_W     = 64;
  localparam int LEN_W    = 32;

  localparam logic [PLANE_W-1:0] PLANE_MAX = 24'h7FFFFF;

  localparam logic [2:0] REG_DIR_X  = 3'd0;
  localparam logic [2:0] REG_DIR_Y  = 3'd1;
  localparam logic [2:0] REG_DIR_Z  = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

endpackage

[rtl/pcrg_mul.sv]
`timescale 1ns / 1ps
// pcrg_mul: shared signed multiplier with registered product
// depends on pcrg_pkg

module pcrg_mul import pcrg_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  mul_a,
  input  logic signed [MUL_W-1:0]  mul_b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

[rtl/pcrg_isqrt.sv]
`timescale 1ns / 1ps
// pcrg_isqrt: floor square root of a 64-bit value, two bits per cycle
// depends on pcrg_pkg

module pcrg_isqrt import pcrg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SQ_W-1:0]  radicand,
  output logic             done_r,
  output logic [LEN_W-1:0] root
);

  logic            busy_r;
  logic [4:0]      cnt_r;
  logic [SQ_W-1:0] n_r, r_r, bit_r;
  logic [SQ_W-1:0] trial;
  logic            ge;

  assign trial = r_r + bit_r;
  assign ge    = n_r >= trial;
  assign root  = r_r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= radicand;
      r_r   <= '0;
      bit_r <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy_r) begin
      if (ge) begin
        n_r <= n_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

[rtl/pcrg_div.sv]
`timescale 1ns / 1ps
// pcrg_div: restoring divider, one quotient bit per cycle, divisor given pre-shifted
// depends on pcrg_pkg

module pcrg_div import pcrg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  num,
  input  logic [DIV_W-1:0]  den,
  input  logic [ITER_W-1:0] iters,
  output logic              done_r,
  output logic [DIV_QW-1:0] quo_r
);

  logic              busy_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DIV_W-1:0]  rem_r, dsh_r;
  logic              ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters - ITER_W'(1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - ITER_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[DIV_QW-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

[rtl/pinhole_camera_ray_generator.sv]
`timescale 1ns / 1ps
// pinhole_camera_ray_generator: one normalized primary ray per input word, raster order
// per word: plane offsets, 3 multiply-adds, 3 squares, square root and 3 divides before
// out_valid, plus frame setup on restart (right and up vectors, then plane divides)
// one word in flight: the next word waits until the ray is loaded, longer while out_stall holds the last ray
// synchronous active-low reset: view (0,0,1.0), 640x480, no setup held (first word sets up)
// depends on pcrg_pkg, pcrg_mul, pcrg_isqrt, pcrg_div

module pinhole_camera_ray_generator import pcrg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_restart_frame,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_ray_x,
  output logic signed [15:0]  out_ray_y,
  output logic signed [15:0]  out_ray_z,
  output logic [CNT_W-1:0]    out_column,
  output logic [CNT_W-1:0]    out_row,
  output logic                out_frame_last,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_R_LOAD    = 5'd1;
  localparam logic [4:0] ST_UP_M0     = 5'd2;
  localparam logic [4:0] ST_UP_M1     = 5'd3;
  localparam logic [4:0] ST_UP_M2     = 5'd4;
  localparam logic [4:0] ST_UP_M3     = 5'd5;
  localparam logic [4:0] ST_UP_M4     = 5'd6;
  localparam logic [4:0] ST_SD_H      = 5'd7;
  localparam logic [4:0] ST_SD_HW     = 5'd8;
  localparam logic [4:0] ST_SD_C      = 5'd9;
  localparam logic [4:0] ST_SD_CW     = 5'd10;
  localparam logic [4:0] ST_SD_R      = 5'd11;
  localparam logic [4:0] ST_SD_RW     = 5'd12;
  localparam logic [4:0] ST_RAY_SX    = 5'd13;
  localparam logic [4:0] ST_RAY_SY    = 5'd14;
  localparam logic [4:0] ST_RAY_SYW   = 5'd15;
  localparam logic [4:0] ST_RAY_C0    = 5'd16;
  localparam logic [4:0] ST_RAY_C1    = 5'd17;
  localparam logic [4:0] ST_RAY_C2    = 5'd18;
  localparam logic [4:0] ST_NRM_SQ    = 5'd19;
  localparam logic [4:0] ST_NRM_ACC   = 5'd20;
  localparam logic [4:0] ST_NRM_SQRT  = 5'd21;
  localparam logic [4:0] ST_NRM_DIV   = 5'd22;
  localparam logic [4:0] ST_NRM_DWAIT = 5'd23;
  localparam logic [4:0] ST_OUT       = 5'd24;

  localparam logic [1:0] TGT_RIGHT = 2'd0;
  localparam logic [1:0] TGT_UP    = 2'd1;
  localparam logic [1:0] TGT_RAY   = 2'd2;

  localparam int CW    = 34;
  localparam int ACC_W = 42;
  localparam int DIFF_W = 40;

  logic [4:0]  state_r, state_nxt;
  logic [1:0]  idx_r, tgt_r;

  logic signed [15:0]  dir_r [3];
  logic [DIM_W-1:0]    fw_r, fh_r;
  logic signed [15:0]  rv_r [3];
  logic signed [15:0]  uv_r [3];
  logic signed [15:0]  o_r [3];
  logic [PLANE_W-1:0]  half_r, cstep_r, rstep_r;
  logic signed [PLANE_W-1:0] sx_r, sy_r;
  logic [CNT_W-1:0]    ccnt_r, rcnt_r;
  logic                setup_valid_r;
  logic signed [CW-1:0]    c_r [3];
  logic signed [ACC_W-1:0] acc_r;
  logic [SQ_W-1:0]     sum_r;
  logic [LEN_W-1:0]    len_r;
  logic                out_valid_r;
  logic signed [15:0]  ray_x_r, ray_y_r, ray_z_r;
  logic [CNT_W-1:0]    col_r, row_r;
  logic                last_r;

  logic [DIM_W-1:0]    w_cl, h_cl;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic                sq_start, sq_done;
  logic [SQ_W-1:0]     sum_add;
  logic [LEN_W-1:0]    sq_root;
  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_num, div_den;
  logic [ITER_W-1:0]   div_iters;
  logic [DIV_QW-1:0]   div_q;
  logic signed [CW-1:0] c_sel;
  logic [CW-1:0]       c_abs;
  logic signed [15:0]  o_new;
  logic                nrm_step, nrm_last;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]    acc_abs;
  logic [CW-1:0]       acc_rnd;
  logic signed [CW-1:0] c_rnd;
  logic signed [DIFF_W-1:0] sx_diff, sy_diff;
  logic [PLANE_W-1:0]  plane_q;
  logic                accept, last_col, last_row, out_load;

  function automatic logic signed [PLANE_W-1:0] clamp_plane(input logic signed [DIFF_W-1:0] v);
    if (v > DIFF_W'(signed'({1'b0, PLANE_MAX}))) begin
      return PLANE_MAX;
    end else if (v < -DIFF_W'(signed'({1'b0, PLANE_MAX})) - DIFF_W'(1)) begin
      return {1'b1, {(PLANE_W-1){1'b0}}};
    end else begin
      return v[PLANE_W-1:0];
    end
  endfunction

  always_comb begin
    if (fw_r < DIM_W'(2)) w_cl = DIM_W'(2);
    else if (fw_r > DIM_W'(MAX_DIM)) w_cl = DIM_W'(MAX_DIM);
    else w_cl = fw_r;
    if (fh_r < DIM_W'(2)) h_cl = DIM_W'(2);
    else if (fh_r > DIM_W'(MAX_DIM)) h_cl = DIM_W'(MAX_DIM);
    else h_cl = fh_r;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_ray_x = ray_x_r;
  assign out_ray_y = ray_y_r;
  assign out_ray_z = ray_z_r;
  assign out_column = col_r;
  assign out_row    = row_r;
  assign out_frame_last = last_r;

  assign last_col = ({1'b0, ccnt_r} + DIM_W'(1)) >= w_cl;
  assign last_row = ({1'b0, rcnt_r} + DIM_W'(1)) >= h_cl;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // normalize helpers
  assign c_sel   = c_r[idx_r];
  assign c_abs   = c_sel[CW-1] ? -c_sel : c_sel;
  assign sum_add = sum_r + SQ_W'(prod_r[SQ_W-1:0]);
  assign sq_start = (state_r == ST_NRM_ACC) && (idx_r == 2'd2);

  always_comb begin
    if (len_r == '0) begin
      o_new = '0;
    end else if (!c_sel[CW-1]) begin
      o_new = (div_q > DIV_QW'(32767)) ? 16'sh7FFF : signed'(div_q[15:0]);
    end else begin
      o_new = (div_q > DIV_QW'(32768)) ? 16'sh8000 : signed'(-div_q[15:0]);
    end
  end

  assign nrm_step = ((state_r == ST_NRM_DIV) && (len_r == '0)) ||
                    ((state_r == ST_NRM_DWAIT) && div_done);
  assign nrm_last = nrm_step && (idx_r == 2'd2);

  // ray component rounding
  assign acc_sum = acc_r + prod_r[ACC_W-1:0];
  assign acc_abs = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;
  assign acc_rnd = CW'((acc_abs + ACC_W'(128)) >> 8);
  assign c_rnd   = acc_sum[ACC_W-1] ? -signed'(acc_rnd) : signed'(acc_rnd);

  assign sx_diff = DIFF_W'(signed'({1'b0, half_r})) - signed'(prod_r[DIFF_W-1:0]);
  assign sy_diff = DIFF_W'(signed'(1 << PFB)) - signed'(prod_r[DIFF_W-1:0]);
  assign plane_q = (div_q > DIV_QW'(PLANE_MAX)) ? PLANE_MAX : div_q[PLANE_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_NRM_SQ: begin
        mul_a = MUL_W'(c_abs);
        mul_b = MUL_W'(c_abs);
      end
      ST_UP_M0: begin
        mul_a = MUL_W'(rv_r[2]);
        mul_b = MUL_W'(dir_r[1]);
      end
      ST_UP_M1: begin
        mul_a = MUL_W'(rv_r[2]);
        mul_b = MUL_W'(dir_r[0]);
      end
      ST_UP_M2: begin
        mul_a = MUL_W'(rv_r[0]);
        mul_b = MUL_W'(dir_r[2]);
      end
      ST_UP_M3: begin
        mul_a = MUL_W'(rv_r[0]);
        mul_b = MUL_W'(dir_r[1]);
      end
      ST_RAY_SX: begin
        mul_a = signed'(MUL_W'(ccnt_r));
        mul_b = signed'(MUL_W'(cstep_r));
      end
      ST_RAY_SY: begin
        mul_a = signed'(MUL_W'(rcnt_r));
        mul_b = signed'(MUL_W'(rstep_r));
      end
      ST_RAY_C0: begin
        mul_a = MUL_W'(rv_r[idx_r]);
        mul_b = MUL_W'(sx_r);
      end
      ST_RAY_C1: begin
        mul_a = MUL_W'(uv_r[idx_r]);
        mul_b = MUL_W'(sy_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = ITER_W'(DIV_QW);
    case (state_r)
      ST_NRM_DIV: begin
        div_start = len_r != '0;
        div_num   = (DIV_W'(c_abs[LEN_W-1:0]) << VFB) + DIV_W'(len_r >> 1);
        div_den   = DIV_W'(len_r) << VFB;
        div_iters = ITER_W'(VFB + 1);
      end
      ST_SD_H: begin
        div_start = 1'b1;
        div_num   = (DIV_W'(w_cl) << PFB) + DIV_W'(h_cl >> 1);
        div_den   = DIV_W'(h_cl) << (DIV_QW - 1);
      end
      ST_SD_C: begin
        div_start = 1'b1;
        div_num   = (DIV_W'(half_r) << 1) + DIV_W'((w_cl - DIM_W'(1)) >> 1);
        div_den   = DIV_W'(w_cl - DIM_W'(1)) << (DIV_QW - 1);
      end
      ST_SD_R: begin
        div_start = 1'b1;
        div_num   = (DIV_W'(1) << (PFB + 1)) + DIV_W'((h_cl - DIM_W'(1)) >> 1);
        div_den   = DIV_W'(h_cl - DIM_W'(1)) << (DIV_QW - 1);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pcrg_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  pcrg_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_add),
    .done_r   (sq_done),
    .root     (sq_root)
  );

  pcrg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .iters  (div_iters),
    .done_r (div_done),
    .quo_r  (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_restart_frame || !setup_valid_r) ? ST_R_LOAD : ST_RAY_SX;
        end
      end
      ST_R_LOAD:   state_nxt = ST_NRM_SQ;
      ST_UP_M0:    state_nxt = ST_UP_M1;
      ST_UP_M1:    state_nxt = ST_UP_M2;
      ST_UP_M2:    state_nxt = ST_UP_M3;
      ST_UP_M3:    state_nxt = ST_UP_M4;
      ST_UP_M4:    state_nxt = ST_NRM_SQ;
      ST_SD_H:     state_nxt = ST_SD_HW;
      ST_SD_HW:    if (div_done) state_nxt = ST_SD_C;
      ST_SD_C:     state_nxt = ST_SD_CW;
      ST_SD_CW:    if (div_done) state_nxt = ST_SD_R;
      ST_SD_R:     state_nxt = ST_SD_RW;
      ST_SD_RW:    if (div_done) state_nxt = ST_RAY_SX;
      ST_RAY_SX:   state_nxt = ST_RAY_SY;
      ST_RAY_SY:   state_nxt = ST_RAY_SYW;
      ST_RAY_SYW:  state_nxt = ST_RAY_C0;
      ST_RAY_C0:   state_nxt = ST_RAY_C1;
      ST_RAY_C1:   state_nxt = ST_RAY_C2;
      ST_RAY_C2:   state_nxt = (idx_r == 2'd2) ? ST_NRM_SQ : ST_RAY_C0;
      ST_NRM_SQ:   state_nxt = ST_NRM_ACC;
      ST_NRM_ACC:  state_nxt = (idx_r == 2'd2) ? ST_NRM_SQRT : ST_NRM_SQ;
      ST_NRM_SQRT: if (sq_done) state_nxt = ST_NRM_DIV;
      ST_NRM_DIV, ST_NRM_DWAIT: begin
        if (state_r == ST_NRM_DIV && len_r != '0) begin
          state_nxt = ST_NRM_DWAIT;
        end else if (nrm_last) begin
          case (tgt_r)
            TGT_RIGHT: state_nxt = ST_UP_M0;
            TGT_UP:    state_nxt = ST_SD_H;
            default:   state_nxt = ST_OUT;
          endcase
        end else if (nrm_step) begin
          state_nxt = ST_NRM_DIV;
        end
      end
      ST_OUT:      if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      setup_valid_r <= 1'b0;
      ccnt_r        <= '0;
      rcnt_r        <= '0;
      dir_r[0]      <= '0;
      dir_r[1]      <= '0;
      dir_r[2]      <= 16'sd16384;
      fw_r          <= DIM_W'(640);
      fh_r          <= DIM_W'(480);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_X:  dir_r[0] <= signed'(cfg_data);
          REG_DIR_Y:  dir_r[1] <= signed'(cfg_data);
          REG_DIR_Z:  dir_r[2] <= signed'(cfg_data);
          REG_WIDTH:  fw_r <= cfg_data[DIM_W-1:0];
          REG_HEIGHT: fh_r <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_SD_RW && div_done) begin
        setup_valid_r <= 1'b1;
        ccnt_r        <= '0;
        rcnt_r        <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (last_col) begin
          ccnt_r <= '0;
          rcnt_r <= last_row ? '0 : rcnt_r + CNT_W'(1);
        end else begin
          ccnt_r <= ccnt_r + CNT_W'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_R_LOAD: begin
        c_r[0] <= -CW'(dir_r[2]);
        c_r[1] <= '0;
        c_r[2] <= CW'(dir_r[0]);
        tgt_r  <= TGT_RIGHT;
        idx_r  <= 2'd0;
        sum_r  <= '0;
      end
      ST_UP_M1: c_r[0] <= -prod_r[CW-1:0];
      ST_UP_M2: acc_r  <= prod_r[ACC_W-1:0];
      ST_UP_M3: c_r[1] <= acc_r[CW-1:0] - prod_r[CW-1:0];
      ST_UP_M4: begin
        c_r[2] <= prod_r[CW-1:0];
        tgt_r  <= TGT_UP;
        idx_r  <= 2'd0;
        sum_r  <= '0;
      end
      ST_SD_HW: if (div_done) half_r  <= plane_q;
      ST_SD_CW: if (div_done) cstep_r <= plane_q;
      ST_SD_RW: if (div_done) rstep_r <= plane_q;
      ST_RAY_SY:  sx_r <= clamp_plane(sx_diff);
      ST_RAY_SYW: begin
        sy_r  <= clamp_plane(sy_diff);
        idx_r <= 2'd0;
      end
      ST_RAY_C0: acc_r <= ACC_W'(dir_r[idx_r]) <<< PFB;
      ST_RAY_C1: acc_r <= acc_sum;
      ST_RAY_C2: begin
        c_r[idx_r] <= c_rnd;
        if (idx_r == 2'd2) begin
          tgt_r <= TGT_RAY;
          idx_r <= 2'd0;
          sum_r <= '0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      ST_NRM_ACC: begin
        sum_r <= sum_add;
        idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
      end
      ST_NRM_SQRT: if (sq_done) len_r <= sq_root;
      ST_NRM_DIV, ST_NRM_DWAIT: begin
        if (nrm_step) begin
          o_r[idx_r] <= o_new;
          idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
          if (nrm_last && tgt_r == TGT_RIGHT) begin
            rv_r[0] <= o_r[0];
            rv_r[1] <= o_r[1];
            rv_r[2] <= o_new;
          end
          if (nrm_last && tgt_r == TGT_UP) begin
            uv_r[0] <= o_r[0];
            uv_r[1] <= o_r[1];
            uv_r[2] <= o_new;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          ray_x_r <= o_r[0];
          ray_y_r <= o_r[1];
          ray_z_r <= o_r[2];
          col_r   <= ccnt_r;
          row_r   <= rcnt_r;
          last_r  <= last_col && last_row;
        end
      end
      default: ;
    endcase
  end

endmodule

[test/pinhole_camera_ray_generator_tb.sv]
`timescale 1ns / 1ps
// pinhole_camera_ray_generator_tb: random and directed test of the ray generator,
// with its own fixed-point camera model and an ordered store of expected rays
// depends on pcrg_pkg and pinhole_camera_ray_generator

module pinhole_camera_ray_generator_tb;
  import pcrg_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef longint vec3_t [3];
  typedef struct {
    logic signed [15:0] ray_x, ray_y, ray_z;
    logic [CNT_W-1:0]   column, row;
    logic               frame_last;
  } ray_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_ray_x, out_ray_y, out_ray_z;
  logic [CNT_W-1:0] out_column, out_row;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_DIR_X;
  logic [15:0] cfg_data = 16'd0;

  pinhole_camera_ray_generator dut (.*);

  initial forever #4 clk = ~clk;

  // camera model state
  logic [15:0] cam_reg [5];
  vec3_t right_v, up_v;
  longint half_w, col_step, row_step;
  longint col_cnt, row_cnt;
  bit setup_done;

  bit pending_words [$];
  ray_t expected_rays [$];
  int sender_idle, receiver_idle;
  bit hold_sender;
  int fails;
  int quiet_cycles;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vec3_t unit_vec(vec3_t c);
    vec3_t o;
    logic [63:0] sum, len, m, q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = c[i] < 0 ? -c[i] : c[i];
      sum = sum + m * m;
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        m = c[i] < 0 ? -c[i] : c[i];
        q = ((m << VFB) + len / 2) / len;
        if (c[i] < 0) o[i] = q > 32768 ? -32768 : -longint'(q);
        else o[i] = q > 32767 ? 32767 : longint'(q);
      end
    end
    return o;
  endfunction

  function automatic longint dim(logic [2:0] idx);
    return clamp(longint'(cam_reg[idx] & 16'h1fff), 2, MAX_DIM);
  endfunction

  function automatic longint dir(logic [2:0] idx);
    return longint'($signed(cam_reg[idx]));
  endfunction

  function automatic void frame_setup();
    vec3_t c;
    longint w, h, one;
    w = dim(REG_WIDTH);
    h = dim(REG_HEIGHT);
    one = longint'(1) << PFB;
    c[0] = -dir(REG_DIR_Z);
    c[1] = 0;
    c[2] = dir(REG_DIR_X);
    right_v = unit_vec(c);
    c[0] = -right_v[2] * dir(REG_DIR_Y);
    c[1] = right_v[2] * dir(REG_DIR_X) - right_v[0] * dir(REG_DIR_Z);
    c[2] = right_v[0] * dir(REG_DIR_Y);
    up_v = unit_vec(c);
    half_w = clamp((w * one + h / 2) / h, 0, PLANE_MAX);
    col_step = clamp((2 * half_w + (w - 1) / 2) / (w - 1), 0, PLANE_MAX);
    row_step = clamp((2 * one + (h - 1) / 2) / (h - 1), 0, PLANE_MAX);
    col_cnt = 0;
    row_cnt = 0;
    setup_done = 1'b1;
  endfunction

  function automatic void predict_ray(bit restart);
    vec3_t c, o;
    longint sx, sy, t, m, w, h;
    bit last_col, last_row;
    ray_t r;
    if (restart || !setup_done) frame_setup();
    w = dim(REG_WIDTH);
    h = dim(REG_HEIGHT);
    sx = clamp(half_w - col_cnt * col_step, -(longint'(1) << 23), PLANE_MAX);
    sy = clamp((longint'(1) << PFB) - row_cnt * row_step, -(longint'(1) << 23), PLANE_MAX);
    for (int i = 0; i < 3; i++) begin
      t = dir(REG_DIR_X + 3'(i)) * (longint'(1) << PFB) + right_v[i] * sx + up_v[i] * sy;
      m = ((t < 0 ? -t : t) + 128) >>> 8;
      c[i] = t < 0 ? -m : m;
    end
    o = unit_vec(c);
    last_col = col_cnt + 1 >= w;
    last_row = row_cnt + 1 >= h;
    r.ray_x = o[0][15:0];
    r.ray_y = o[1][15:0];
    r.ray_z = o[2][15:0];
    r.column = col_cnt[CNT_W-1:0];
    r.row = row_cnt[CNT_W-1:0];
    r.frame_last = last_col && last_row;
    expected_rays.push_back(r);
    if (last_col) begin
      row_cnt = last_row ? 0 : row_cnt + 1;
      col_cnt = 0;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_ray(in_restart_frame);
      if (pending_words.size() > 0 && !hold_sender && $urandom_range(99) >= sender_idle) begin
        in_valid <= 1'b1;
        in_restart_frame <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor, receiver stall and watchdog
  always @(posedge clk) begin
    ray_t e;
    out_stall <= rst_n && ($urandom_range(99) < receiver_idle);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rays.size() == 0) begin
        $error("unexpected word: column %0d row %0d", out_column, out_row);
        fails++;
      end else begin
        e = expected_rays.pop_front();
        if (out_ray_x !== e.ray_x) begin
          $error("ray_x expected %0d got %0d", e.ray_x, out_ray_x); fails++;
        end
        if (out_ray_y !== e.ray_y) begin
          $error("ray_y expected %0d got %0d", e.ray_y, out_ray_y); fails++;
        end
        if (out_ray_z !== e.ray_z) begin
          $error("ray_z expected %0d got %0d", e.ray_z, out_ray_z); fails++;
        end
        if (out_column !== e.column) begin
          $error("column expected %0d got %0d", e.column, out_column); fails++;
        end
        if (out_row !== e.row) begin
          $error("row expected %0d got %0d", e.row, out_row); fails++;
        end
        if (out_frame_last !== e.frame_last) begin
          $error("frame_last expected %0d got %0d", e.frame_last, out_frame_last); fails++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_rays.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_camera(logic [15:0] dx, dy, dz, w, h);
    logic [15:0] vals [5];
    vals = '{dx, dy, dz, w, h};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= REG_DIR_X + 3'(i);
      cfg_data <= vals[i];
      cam_reg[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_words(int n, int restart_pct);
    for (int i = 0; i < n; i++) pending_words.push_back($urandom_range(99) < restart_pct);
  endtask

  function automatic logic [15:0] rand_dim();
    int k;
    k = $urandom_range(19);
    if (k == 0) return 16'($urandom_range(65535));
    if (k == 1) return 16'd4096;
    if (k == 2) return 16'($urandom_range(1));
    return 16'($urandom_range(2, 9));
  endfunction

  initial begin
    cam_reg = '{16'd0, 16'd0, 16'd16384, 16'd640, 16'd480};
    setup_done = 1'b0;
    col_cnt = 0;
    row_cnt = 0;
    half_w = 0;
    col_step = 0;
    row_step = 0;
    right_v = '{0, 0, 0};
    up_v = '{0, 0, 0};
    sender_idle = 0;
    receiver_idle = 0;
    hold_sender = 1'b0;
    fails = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first word sets up without restart, then corner cameras
    pending_words = '{1'b0, 1'b0, 1'b1, 1'b0};
    drain();
    set_camera(16'h7fff, 16'h8000, 16'h7fff, 16'd2, 16'd2);
    pending_words = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    drain();
    set_camera(16'h0000, 16'h4000, 16'h0000, 16'd3, 16'd2);
    pending_words = '{1'b1, 1'b0, 1'b0};
    drain();
    set_camera(16'h0000, 16'h0000, 16'h0000, 16'd2, 16'd3);
    pending_words = '{1'b1, 1'b0, 1'b0};
    drain();
    set_camera(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd1);
    pending_words = '{1'b1, 1'b0};
    drain();
    // shrink mid-frame without restart: counters wrap at the new size
    set_camera(16'hc000, 16'h2000, 16'h4000, 16'hffff, 16'd4096);
    pending_words = '{1'b1, 1'b0, 1'b0};
    drain();
    set_camera(16'hc000, 16'h2000, 16'h4000, 16'd2, 16'd2);
    pending_words = '{1'b0, 1'b0, 1'b0};
    drain();

    // random phases
    for (int p = 0; p < 12; p++) begin
      sender_idle = p < 4 ? 15 : (p < 8 ? 55 : 0);
      receiver_idle = p < 4 ? 55 : (p < 8 ? 15 : 0);
      set_camera(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)), rand_dim(), rand_dim());
      run_words(30, 8);
      if (p == 5) begin
        @(negedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_rays.size() > 0) @(negedge clk);
        hold_sender = 1'b0;
      end
      run_words(30, 8);
      drain();
    end

    drain();
    repeat (300) @(posedge clk);
    if (fails == 0 && expected_rays.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pcrg_pkg.sv
rtl/pcrg_mul.sv
rtl/pcrg_isqrt.sv
rtl/pcrg_div.sv
rtl/pinhole_camera_ray_generator.sv
test/pinhole_camera_ray_generator_tb.sv
